FILE: hdl/adv_manufacturer_command_extract_macros.svh
// ----------------------------------------------------------------------------
// adv_manufacturer_command_extract_macros.svh
// Assertion macros shared by the advertising command extractor.
// ----------------------------------------------------------------------------
`ifndef ADV_MANUFACTURER_COMMAND_EXTRACT_MACROS_SVH
`define ADV_MANUFACTURER_COMMAND_EXTRACT_MACROS_SVH

// Property that must hold in the same cycle as its trigger
`define AMCE_ASSERT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger
`define AMCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/adv_mce_pkg.sv
// ----------------------------------------------------------------------------
// adv_mce_pkg
// Types and constants of the advertising manufacturer command extractor.
// ----------------------------------------------------------------------------
package adv_mce_pkg;

	// Largest advertising payload handled, in bytes
	localparam int MAX_PACKET_BYTES = 31;
	localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);

	// Payload index: offsets are 5 bits, index saturates at 32
	localparam int OFS_W = 5;
	localparam int IDX_W = OFS_W + 1;

	// Reset values of the configuration registers
	localparam logic [7:0]  RST_AD_TYPE   = 8'hFF;
	localparam logic [15:0] RST_ADDR_TOP  = {8'h58, 8'h2B};
	localparam logic [4:0]  RST_SEQ_OFS   = 5'd6;
	localparam logic [4:0]  RST_CMD_OFS   = 5'd7;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_AD_TYPE  = 2'd0,
		CFG_ADDR_TOP = 2'd1,
		CFG_SEQ_OFS  = 2'd2,
		CFG_CMD_OFS  = 2'd3
	} cfg_idx_t;

	// Phase of the AD structure walk
	typedef enum logic [1:0] {
		PH_LENGTH = 2'd0,
		PH_TYPE   = 2'd1,
		PH_BODY   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// Configuration register set
	typedef struct packed {
		logic [7:0]       ad_type;
		logic [15:0]      addr_top;
		logic [OFS_W-1:0] seq_ofs;
		logic [OFS_W-1:0] cmd_ofs;
	} cfg_t;

	// One input byte with its side information
	typedef struct packed {
		logic [7:0]  adv_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] sender_address_top;
	} item_t;

endpackage

FILE: hdl/adv_mce_cfg.sv
// ----------------------------------------------------------------------------
// adv_mce_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module adv_mce_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	output adv_mce_pkg::cfg_t  cfg
);
	import adv_mce_pkg::*;

	cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ad_type  <= RST_AD_TYPE;
			cfg_q.addr_top <= RST_ADDR_TOP;
			cfg_q.seq_ofs  <= RST_SEQ_OFS;
			cfg_q.cmd_ofs  <= RST_CMD_OFS;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AD_TYPE:  cfg_q.ad_type  <= cfg_wdata[7:0];
				CFG_ADDR_TOP: cfg_q.addr_top <= cfg_wdata;
				CFG_SEQ_OFS:  cfg_q.seq_ofs  <= cfg_wdata[OFS_W-1:0];
				CFG_CMD_OFS:  cfg_q.cmd_ofs  <= cfg_wdata[OFS_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/adv_mce_walk.sv
// ----------------------------------------------------------------------------
// adv_mce_walk
// AD structure walk state, payload capture and the result register.
// ----------------------------------------------------------------------------
`include "adv_manufacturer_command_extract_macros.svh"

module adv_mce_walk (
	input  logic               clk,
	input  logic               arst_n,
	input  adv_mce_pkg::cfg_t  cfg,
	input  logic               step,       // process item this cycle
	input  adv_mce_pkg::item_t item,
	output logic               slot_free,  // result register can take a new value
	output logic               res_valid,
	input  logic               res_ready,
	output logic [15:0]        res_data    // command_byte, sequence_byte
);
	import adv_mce_pkg::*;

	// Walk state
	phase_t           phase_q, phase_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       left_q, left_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic             amatch_q, amatch_n;
	logic             inw_q, inw_n;
	logic [7:0]       cseq_q, cseq_n;
	logic [7:0]       ccmd_q, ccmd_n;
	logic [7:0]       lseq_q, lseq_n;

	// Result register
	logic             res_valid_q;
	logic [7:0]       res_cmd_q, res_seq_q;

	phase_t           ph;
	logic [CNT_W-1:0] cnt;
	logic             inw;
	logic [7:0]       left_dec;
	logic             finish;
	logic             emit;

	// Next state for one byte
	always_comb begin
		ph       = item.first_byte ? PH_LENGTH : phase_q;
		cnt      = item.first_byte ? '0 : cnt_q;
		inw      = item.first_byte ? 1'b0 : inw_q;
		amatch_n = item.first_byte ? (item.sender_address_top == cfg.addr_top) : amatch_q;
		left_dec = left_q - 8'd1;

		phase_n = ph;
		cnt_n   = cnt;
		inw_n   = inw;
		left_n  = left_q;
		idx_n   = idx_q;
		cseq_n  = cseq_q;
		ccmd_n  = ccmd_q;
		finish  = 1'b0;

		if (cnt >= CNT_W'(MAX_PACKET_BYTES)) begin
			// packet too long: stop the walk, byte ignored
			phase_n = PH_DONE;
		end else begin
			cnt_n = cnt + CNT_W'(1);
			unique case (ph)
				PH_LENGTH: begin
					if (item.adv_byte == 8'd0) begin
						phase_n = PH_DONE;
					end else begin
						left_n  = item.adv_byte;
						phase_n = PH_TYPE;
					end
				end
				PH_TYPE: begin
					left_n = left_dec;
					if (item.adv_byte == cfg.ad_type) begin
						inw_n  = 1'b1;
						idx_n  = '0;
						cseq_n = '0;
						ccmd_n = '0;
						if (left_dec == 8'd0) finish = 1'b1;
						else phase_n = PH_BODY;
					end else begin
						inw_n   = 1'b0;
						phase_n = (left_dec == 8'd0) ? PH_LENGTH : PH_BODY;
					end
				end
				PH_BODY: begin
					if (inw) begin
						if (idx_q == {1'b0, cfg.seq_ofs}) cseq_n = item.adv_byte;
						if (idx_q == {1'b0, cfg.cmd_ofs}) ccmd_n = item.adv_byte;
						// index saturates once past every reachable offset
						if (!idx_q[IDX_W-1]) idx_n = idx_q + IDX_W'(1);
					end
					left_n = left_dec;
					if (left_dec == 8'd0) begin
						if (inw) finish = 1'b1;
						else phase_n = PH_LENGTH;
					end
				end
				PH_DONE: begin
				end
			endcase
			if (finish) phase_n = PH_DONE;
			if (item.last_byte) phase_n = PH_DONE;
		end

		// new payload when the sequence byte changed
		emit   = finish && amatch_n && (cseq_n != lseq_q);
		lseq_n = emit ? cseq_n : lseq_q;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			cnt_q    <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			amatch_q <= 1'b0;
			inw_q    <= 1'b0;
			cseq_q   <= '0;
			ccmd_q   <= '0;
			lseq_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			left_q   <= left_n;
			idx_q    <= idx_n;
			amatch_q <= amatch_n;
			inw_q    <= inw_n;
			cseq_q   <= cseq_n;
			ccmd_q   <= ccmd_n;
			lseq_q   <= lseq_n;
		end
	end

	assign slot_free = !res_valid_q || res_ready;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_cmd_q <= ccmd_n;
			res_seq_q <= cseq_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = {res_seq_q, res_cmd_q};

	// Checks
	`AMCE_ASSERT(a_no_overwrite, clk, arst_n, step, !res_valid_q || res_ready, "result overwritten")
	`AMCE_ASSERT_NEXT(a_emit_ends_walk, clk, arst_n, step && emit, phase_q == PH_DONE, "walk open after result")
	`AMCE_ASSERT_NEXT(a_emit_keeps_seq, clk, arst_n, step && emit, lseq_q == res_seq_q, "sequence not kept")
	`AMCE_ASSERT(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_PACKET_BYTES), "byte count overrun")

endmodule

FILE: hdl/adv_manufacturer_command_extract.sv
// ----------------------------------------------------------------------------
// adv_manufacturer_command_extract
// Advertising packet walker that extracts a manufacturer command byte.
// ----------------------------------------------------------------------------
// Takes one advertising byte per cycle (tuser marks the first byte of a packet,
// tlast the last) and walks its length/type structures. At the first structure
// of the configured AD type, if it fits in the packet and the sender address
// matched, the bytes at the sequence and command offsets are picked out; a new
// sequence value gives one request on the master side. Throughput is one byte
// per clock; each byte passes the input register, then the walk logic into the
// result register; the input stalls only while a result is held unread.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// should only change while no packet is in flight.
module adv_manufacturer_command_extract (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [7:0] adv_byte, [23:8] sender_address_top
	input  logic        s_tlast,    // last_byte
	input  logic        s_tuser,    // first_byte
	// command out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // [7:0] command_byte, [15:8] sequence_byte
);
	import adv_mce_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  slot_free;
	logic  step;
	logic  accept;

	adv_mce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register handshake
	assign step     = valid_s1 && slot_free;
	assign s_tready = !valid_s1 || slot_free;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.adv_byte           <= s_tdata[7:0];
			item_s1.sender_address_top <= s_tdata[23:8];
			item_s1.first_byte         <= s_tuser;
			item_s1.last_byte          <= s_tlast;
		end
	end

	adv_mce_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.item      (item_s1),
		.slot_free (slot_free),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata)
	);

endmodule
